// ----- sv/htb_pkg.sv -----
// ---------------------------------------------------------------------------
// htb_pkg
// Shared types, codes and character helpers for the hex text parser.
// ---------------------------------------------------------------------------
package htb_pkg;

	// Input operation carried in s_axis_tuser
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Result kind carried in m_axis_tuser
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// End status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BAD  = 2'd1;
	localparam logic [1:0] STAT_NONE = 2'd2;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int TDATA_OUT_W = 16;
	localparam int TDATA_PAD_W = TDATA_OUT_W - 10;

	// Position within the current token
	typedef enum logic [4:0] {
		PH_BETWEEN = 5'b00001,
		PH_ZERO    = 5'b00010,
		PH_LEAD    = 5'b00100,
		PH_DIGITS  = 5'b01000,
		PH_TRAIL   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [1:0] status;
	} result_t;

	// {valid, value} of a hex digit character
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ----- sv/htb_core.sv -----
// ---------------------------------------------------------------------------
// htb_core
// Tokenizer state and per-character update; yields at most one result.
// ---------------------------------------------------------------------------
module htb_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              op,
	input  logic [7:0]        ch,
	output logic              res_valid,
	output htb_pkg::result_t  res
);

	htb_pkg::phase_t phase_q, phase_n;
	logic [3:0] hi_q, hi_n;
	logic       odd_q, odd_n;
	logic       comment_q, comment_n;
	logic       slash_q, slash_n;
	logic       any_q, any_n;
	logic       err_q, err_n;

	always_comb begin
		logic [4:0] hd;
		logic       close_bad;
		hd        = htb_pkg::hex_digit(ch);
		close_bad = (phase_q == htb_pkg::PH_ZERO) || odd_q;
		phase_n   = phase_q;
		hi_n      = hi_q;
		odd_n     = odd_q;
		comment_n = comment_q;
		slash_n   = slash_q;
		any_n     = any_q;
		err_n     = err_q;
		res_valid = 1'b0;
		res       = '0;
		if (step) begin
			if (op == htb_pkg::OP_END) begin
				res_valid = 1'b1;
				res.kind  = htb_pkg::KIND_END;
				if (err_q || close_bad)
					res.status = htb_pkg::STAT_BAD;
				else if (any_q)
					res.status = htb_pkg::STAT_OK;
				else
					res.status = htb_pkg::STAT_NONE;
				phase_n   = htb_pkg::PH_BETWEEN;
				hi_n      = 4'd0;
				odd_n     = 1'b0;
				comment_n = 1'b0;
				slash_n   = 1'b0;
				any_n     = 1'b0;
				err_n     = 1'b0;
			end else if (!err_q) begin
				if (ch == htb_pkg::CH_NL || (!comment_q && (ch == htb_pkg::CH_HASH ||
						(ch == htb_pkg::CH_SLASH && slash_q)))) begin
					// token ends; newline leaves a comment, the others open one
					err_n     = close_bad;
					phase_n   = htb_pkg::PH_BETWEEN;
					hi_n      = 4'd0;
					odd_n     = 1'b0;
					comment_n = (ch != htb_pkg::CH_NL);
					slash_n   = 1'b0;
				end else if (!comment_q) begin
					slash_n = (ch == htb_pkg::CH_SLASH);
					if (htb_pkg::is_space(ch)) begin
						err_n   = close_bad;
						phase_n = htb_pkg::PH_BETWEEN;
						hi_n    = 4'd0;
						odd_n   = 1'b0;
					end else if (phase_q == htb_pkg::PH_BETWEEN && ch == htb_pkg::CH_ZERO) begin
						phase_n = htb_pkg::PH_ZERO;
					end else if (phase_q == htb_pkg::PH_ZERO &&
							(ch == htb_pkg::CH_X_LO || ch == htb_pkg::CH_X_UP)) begin
						phase_n = htb_pkg::PH_LEAD;
					end else begin
						// a leading zero with no x is the first digit after all
						if (phase_q == htb_pkg::PH_ZERO) begin
							phase_n = htb_pkg::PH_DIGITS;
							hi_n    = 4'd0;
							odd_n   = 1'b1;
						end
						if (hd[4]) begin
							if (phase_n == htb_pkg::PH_TRAIL) begin
								err_n = 1'b1;
							end else begin
								phase_n = htb_pkg::PH_DIGITS;
								if (odd_n) begin
									res_valid     = 1'b1;
									res.kind      = htb_pkg::KIND_DATA;
									res.data_byte = {hi_n, hd[3:0]};
									hi_n          = 4'd0;
									odd_n         = 1'b0;
									any_n         = 1'b1;
								end else begin
									hi_n  = hd[3:0];
									odd_n = 1'b1;
								end
							end
						end else if (phase_n == htb_pkg::PH_DIGITS) begin
							phase_n = htb_pkg::PH_TRAIL;
						end else if (phase_n == htb_pkg::PH_BETWEEN) begin
							phase_n = htb_pkg::PH_LEAD;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= htb_pkg::PH_BETWEEN;
			hi_q      <= 4'd0;
			odd_q     <= 1'b0;
			comment_q <= 1'b0;
			slash_q   <= 1'b0;
			any_q     <= 1'b0;
			err_q     <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			hi_q      <= hi_n;
			odd_q     <= odd_n;
			comment_q <= comment_n;
			slash_q   <= slash_n;
			any_q     <= any_n;
			err_q     <= err_n;
		end
	end

endmodule

// ----- sv/hex_text_to_bytes_parser.sv -----
// ---------------------------------------------------------------------------
// hex_text_to_bytes_parser
// Streams text characters in and the hex bytes written in them out.
// ---------------------------------------------------------------------------
// Input channel s_axis: one transaction per character (tuser = 0, tdata = code)
// or an end-of-text marker (tuser = 1). Output channel m_axis: one transaction
// per parsed byte (tuser = 0, tdata[7:0] = byte) and one per end marker
// (tuser = 1, tdata[9:8] = status: ok, bad token, no bytes).
// An accepted character is held in an input register; the tokenizer then
// updates its state and writes any result into a two-entry output queue,
// whose head drives m_axis. The input register and the output queue lie
// between acceptance and m_axis, and a full queue can hold a character in
// the input register. Throughput is one character per cycle while the queue
// is not full. s_axis_tready depends only on registers: it drops only when the
// output queue holds two results and the input register is occupied.
// When the receiver stalls, results wait in the queue and the input keeps
// flowing until the queue is full. Reset empties the queue and input register
// and returns the tokenizer to the start of a text. After a bad token no more
// bytes come out until the end marker, whose status tells the receiver to
// drop what it got.
// ---------------------------------------------------------------------------
module hex_text_to_bytes_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic [0:0]  s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, rest zero
	output logic [0:0]  m_axis_tuser    // [0] kind
);

	logic       s1_valid_q;
	logic       op_s1;
	logic [7:0] ch_s1;
	logic [1:0] cnt_q;
	logic       adv, push, pop, s_acc;
	logic       res_valid;
	htb_pkg::result_t res;
	htb_pkg::result_t out0_q, out1_q;

	assign adv           = s1_valid_q && (cnt_q != 2'd2);
	assign s_axis_tready = !s1_valid_q || (cnt_q != 2'd2);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign push          = adv && res_valid;
	assign pop           = m_axis_tvalid && m_axis_tready;

	htb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.op        (op_s1),
		.ch        (ch_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1 <= s_axis_tuser[0];
			ch_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= 2'(cnt_q + 2'd1);
		end else if (pop && !push) begin
			cnt_q <= 2'(cnt_q - 2'd1);
		end
	end

	// head drives the port, second entry is the skid slot
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				out0_q <= out1_q;
				if (push)
					out1_q <= res;
			end else if (push) begin
				out0_q <= res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0)
				out0_q <= res;
			else
				out1_q <= res;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tuser  = out0_q.kind;
	assign m_axis_tdata  = {{htb_pkg::TDATA_PAD_W{1'b0}}, out0_q.status, out0_q.data_byte};

endmodule

// ----- sv/htb_chk.sv -----
// ---------------------------------------------------------------------------
// htb_chk
// Port-level checks for the hex text parser, bound to the top level.
// ---------------------------------------------------------------------------
module htb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// a stalled output transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output transaction changed while stalled");

	// data carries no status, end carries no byte and a legal status
	a_format: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'd0) &&
			((m_axis_tuser[0] == htb_pkg::KIND_DATA) ? (m_axis_tdata[9:8] == 2'd0) :
			((m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[9:8] != 2'd3))))
		else $error("malformed output transaction");

	// input only backs up when results are waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// a full queue that drains must reopen the input on the next cycle
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && m_axis_tready |=> s_axis_tready)
		else $error("input stayed blocked after output drained");

endmodule

bind hex_text_to_bytes_parser htb_chk u_htb_chk (.*);
